// ----- hdl/kdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kdc_pkg;

  localparam int NUM_KEYS  = 4;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DBL_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_ENABLE = 3'd4;

  // Reset values of the registers
  localparam logic [NUM_KEYS-1:0] RST_ACTIVE_MASK = '0;
  localparam logic [CNT_W-1:0]    RST_DEBOUNCE    = 8'd2;
  localparam logic [CNT_W-1:0]    RST_WINDOW      = 8'd30;

  // Click phase of one key
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_WAIT   = 3'b010,
    PH_SECOND = 3'b100
  } phase_t;

  // Settings shared by all lanes
  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] window;
    logic             dbl_enable;
    logic             click_enable;
  } lane_cfg_t;

  // Events one lane raises for one word
  typedef struct packed {
    logic down;
    logic up;
    logic click;
    logic dbl;
  } lane_ev_t;

endpackage

`default_nettype wire

// ----- hdl/kdc_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kdc_lane (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic                  level,
  input  wire logic                  act,
  input  wire kdc_pkg::lane_cfg_t    cfg,
  output kdc_pkg::lane_ev_t          ev
);

  logic                      stable;
  logic [kdc_pkg::CNT_W-1:0] dcount;
  kdc_pkg::phase_t           phase;
  logic [kdc_pkg::CNT_W-1:0] wcount;

  logic                      stable_next;
  logic [kdc_pkg::CNT_W-1:0] dcount_next;
  kdc_pkg::phase_t           phase_next;
  logic [kdc_pkg::CNT_W-1:0] wcount_next;

  logic                      pressed;
  logic                      diff;
  logic                      flip;
  logic [kdc_pkg::CNT_W-1:0] dcount_inc;
  logic [kdc_pkg::CNT_W-1:0] wcount_inc;
  kdc_pkg::phase_t           phase_mid;
  logic [kdc_pkg::CNT_W-1:0] wcount_mid;

  // Debounce the pin against the stable state
  always_comb begin
    pressed     = (level == act);
    diff        = (pressed != stable);
    dcount_inc  = dcount + 1'b1;
    flip        = diff && (dcount_inc >= cfg.debounce_ticks);
    stable_next = flip ? pressed : stable;
    dcount_next = (diff && !flip) ? dcount_inc : '0;
  end

  // Track releases and the double-click window
  always_comb begin
    ev.down     = flip && pressed;
    ev.up       = flip && !pressed;
    ev.click    = 1'b0;
    ev.dbl      = 1'b0;
    phase_mid   = phase;
    wcount_mid  = wcount;
    wcount_inc  = '0;
    phase_next  = phase;
    wcount_next = wcount;

    if (ev.up) begin
      if (cfg.dbl_enable) begin
        case (phase)
          kdc_pkg::PH_WAIT:   phase_mid = kdc_pkg::PH_SECOND;
          kdc_pkg::PH_SECOND: phase_mid = kdc_pkg::PH_SECOND;
          default: begin
            phase_mid  = kdc_pkg::PH_WAIT;
            wcount_mid = '0;
          end
        endcase
      end else if (cfg.click_enable) begin
        ev.click = 1'b1;
      end
    end

    phase_next  = phase_mid;
    wcount_next = wcount_mid;
    wcount_inc  = wcount_mid + 1'b1;
    if (cfg.dbl_enable) begin
      case (phase_mid)
        kdc_pkg::PH_WAIT: begin
          if (!stable_next) begin
            if (wcount_inc >= cfg.window) begin
              phase_next  = kdc_pkg::PH_IDLE;
              wcount_next = '0;
              ev.click    = 1'b1;
            end else begin
              wcount_next = wcount_inc;
            end
          end
        end
        kdc_pkg::PH_SECOND: begin
          phase_next  = kdc_pkg::PH_IDLE;
          wcount_next = '0;
          ev.dbl      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Advance the key state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      dcount <= '0;
      phase  <= kdc_pkg::PH_IDLE;
      wcount <= '0;
    end else if (accept) begin
      stable <= stable_next;
      dcount <= dcount_next;
      phase  <= phase_next;
      wcount <= wcount_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/kdc_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kdc_merge (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  accept,
  input  wire kdc_pkg::lane_ev_t [kdc_pkg::NUM_KEYS-1:0] ev,
  output logic                                       full,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [kdc_pkg::NUM_KEYS-1:0]               down_events,
  output logic [kdc_pkg::NUM_KEYS-1:0]               up_events,
  output logic [kdc_pkg::NUM_KEYS-1:0]               click_events,
  output logic [kdc_pkg::NUM_KEYS-1:0]               double_click_events
);

  logic [kdc_pkg::NUM_KEYS-1:0] down_w, up_w, click_w, dbl_w;
  logic [kdc_pkg::NUM_KEYS-1:0] skid_down, skid_up, skid_click, skid_dbl;
  logic                         skid_valid;
  logic                         take;

  // Gather lane events into words
  always_comb begin
    for (int k = 0; k < kdc_pkg::NUM_KEYS; k++) begin
      down_w[k]  = ev[k].down;
      up_w[k]    = ev[k].up;
      click_w[k] = ev[k].click;
      dbl_w[k]   = ev[k].dbl;
    end
  end

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  // Hold control of the output and skid stages
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payload words
  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      if (skid_valid) begin
        down_events         <= skid_down;
        up_events           <= skid_up;
        click_events        <= skid_click;
        double_click_events <= skid_dbl;
      end else if (accept) begin
        down_events         <= down_w;
        up_events           <= up_w;
        click_events        <= click_w;
        double_click_events <= dbl_w;
      end
    end else if (accept) begin
      skid_down  <= down_w;
      skid_up    <= up_w;
      skid_click <= click_w;
      skid_dbl   <= dbl_w;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/key_debounce_click_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted word's result is registered in the output register, or in the
// skid register while the output stalls. One word per cycle while in_stall is
// low; each key has its own lane, all lanes update in the accepting cycle, and the registers decouple.
// Reset (rst, synchronous): all keys released, counters and click phases
// cleared, registers back to mask 0, debounce 2, window 30, both enables on.

module key_debounce_click_detector (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [kdc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [kdc_pkg::CFG_DAT_W-1:0]         cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [kdc_pkg::NUM_KEYS-1:0]          pin_levels,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [kdc_pkg::NUM_KEYS-1:0]               down_events,
  output logic [kdc_pkg::NUM_KEYS-1:0]               up_events,
  output logic [kdc_pkg::NUM_KEYS-1:0]               click_events,
  output logic [kdc_pkg::NUM_KEYS-1:0]               double_click_events
);

  logic [kdc_pkg::NUM_KEYS-1:0]              active_mask;
  kdc_pkg::lane_cfg_t                        cfg;
  kdc_pkg::lane_ev_t [kdc_pkg::NUM_KEYS-1:0] ev;
  logic                                      full;
  logic                                      accept;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask      <= kdc_pkg::RST_ACTIVE_MASK;
      cfg.debounce_ticks <= kdc_pkg::RST_DEBOUNCE;
      cfg.window       <= kdc_pkg::RST_WINDOW;
      cfg.dbl_enable   <= 1'b1;
      cfg.click_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        kdc_pkg::REG_ACTIVE_MASK:  active_mask <= cfg_data[kdc_pkg::NUM_KEYS-1:0];
        kdc_pkg::REG_DEBOUNCE:     cfg.debounce_ticks <= cfg_data;
        kdc_pkg::REG_WINDOW:       cfg.window <= cfg_data;
        kdc_pkg::REG_DBL_ENABLE:   cfg.dbl_enable <= cfg_data[0];
        kdc_pkg::REG_CLICK_ENABLE: cfg.click_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // One lane per key
  for (genvar k = 0; k < kdc_pkg::NUM_KEYS; k++) begin : g_lane
    kdc_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .accept (accept),
      .level  (pin_levels[k]),
      .act    (active_mask[k]),
      .cfg    (cfg),
      .ev     (ev[k])
    );
  end

  // Merge lane events and buffer the result word
  kdc_merge u_merge (
    .clk                 (clk),
    .rst                 (rst),
    .accept              (accept),
    .ev                  (ev),
    .full                (full),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .down_events         (down_events),
    .up_events           (up_events),
    .click_events        (click_events),
    .double_click_events (double_click_events)
  );

endmodule

`default_nettype wire
